[rtl/size_class_heap_allocator_assert.svh]
// Assertion macros used by the allocator controller.
`ifndef SIZE_CLASS_HEAP_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_HEAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[rtl/scha_pkg.sv]
package scha_pkg;

  localparam int ADDR_BITS      = 20;
  localparam int SMALL_CLASSES  = 12;
  localparam int BIG_ROUND_BITS = 16;
  localparam int GRAN_BITS      = 4;

  localparam int GRAN_W    = ADDR_BITS - GRAN_BITS;
  localparam int LINK_W    = GRAN_W + 1;
  localparam int CAPG_W    = GRAN_W + 1;
  localparam int REG_W     = 21;
  localparam int PTR_W     = 20;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NEED_W    = REG_W + 1;
  localparam int CAPB_W    = (BIG_ROUND_BITS >= NEED_W) ? BIG_ROUND_BITS + 1 : NEED_W + 1;
  localparam int SUM_W     = CAPB_W + 1;
  localparam int K_W       = $clog2(SMALL_CLASSES);

  localparam logic [SUM_W-1:0] SPACE = SUM_W'(1) << ADDR_BITS;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_HEAP = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NULL     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_R1_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R1_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R2_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R2_END   = 3'd3;

  localparam logic [REG_W-1:0] R1_START_RST = 21'd4096;
  localparam logic [REG_W-1:0] R1_END_RST   = 21'd524288;
  localparam logic [REG_W-1:0] R2_START_RST = 21'd589824;
  localparam logic [REG_W-1:0] R2_END_RST   = 21'd1048576;

  typedef struct packed {
    logic              valid;
    logic [CAPG_W-1:0] cap_g;
    logic [LINK_W-1:0] next;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef struct packed {
    logic [REG_W-1:0] r1_start;
    logic [REG_W-1:0] r1_end;
    logic [REG_W-1:0] r2_start;
    logic [REG_W-1:0] r2_end;
  } cfg_t;

  typedef struct packed {
    logic             start_we;
    logic [REG_W-1:0] value;
  } cfg_ld_t;

endpackage

[rtl/scha_ifs.sv]
interface scha_req_if import scha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [REG_W-1:0] request_bytes;
  logic [PTR_W-1:0] block_address;
  modport source (output valid, cmd, request_bytes, block_address, input ready);
  modport sink (input valid, cmd, request_bytes, block_address, output ready);
endinterface

interface scha_rsp_if import scha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PTR_W-1:0]  result_address;
  logic [REG_W-1:0]  usable_bytes;
  logic [STAT_W-1:0] status;
  modport source (output valid, result_address, usable_bytes, status, input ready);
  modport sink (input valid, result_address, usable_bytes, status, output ready);
endinterface

[rtl/scha_hdr_ram.sv]
module scha_hdr_ram #(
  parameter int W  = 35,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/scha_ctrl.sv]
`include "size_class_heap_allocator_assert.svh"

module scha_ctrl import scha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  scha_req_if.sink          req,
  scha_rsp_if.source        rsp,
  input  cfg_t              cfg,
  input  cfg_ld_t           cfg_ld,
  output logic              mem_we,
  output logic [GRAN_W-1:0] mem_waddr,
  output hdr_t              mem_wdata,
  output logic [GRAN_W-1:0] mem_raddr,
  input  hdr_t              mem_rdata
);

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b0000000001,
    S_IDLE      = 10'b0000000010,
    S_DECODE    = 10'b0000000100,
    S_POP_EVAL  = 10'b0000001000,
    S_WALK_RD   = 10'b0000010000,
    S_WALK_EVAL = 10'b0000100000,
    S_LINK_FIX  = 10'b0001000000,
    S_BUMP      = 10'b0010000000,
    S_HDR_EVAL  = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LINK_W-1:0] heads_r [SMALL_CLASSES];
  logic [LINK_W-1:0] heads_nxt [SMALL_CLASSES];
  logic [LINK_W-1:0] big_head_r, big_head_nxt;
  logic [REG_W-1:0]  bump_r, bump_nxt;
  logic              r2_r, r2_nxt;
  logic [GRAN_W-1:0] clr_r, clr_nxt;

  logic [CMD_W-1:0]  cmd_r;
  logic [REG_W-1:0]  req_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [CAPG_W-1:0] cap_g_r, cap_g_nxt;
  logic [CAPB_W-1:0] capb_r, capb_nxt;
  logic [GRAN_W-1:0] g_r, g_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [GRAN_W-1:0] prev_g_r, prev_g_nxt;
  hdr_t              prev_hdr_r, prev_hdr_nxt;
  logic              prev_ok_r, prev_ok_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;

  logic [PTR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [REG_W-1:0]  res_use_r, res_use_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PTR_W-1:0]  out_addr_r;
  logic [REG_W-1:0]  out_use_r;
  logic [STAT_W-1:0] out_stat_r;
  logic              out_load;

  logic              accept;

  // Class of an allocation and its big-block rounding.
  logic [NEED_W-1:0] need;
  logic [K_W-1:0]    k_alloc;
  logic              small_alloc;
  logic [CAPB_W-1:0] round_mask;
  logic [CAPB_W-1:0] big_cap;

  // Class of a block being freed.
  logic [K_W-1:0]    k_free;
  logic              small_free;

  // Bump pointer fit tests.
  logic [SUM_W-1:0]  lim_one, lim_two, lim_cur;
  logic [SUM_W-1:0]  sum_cur, sum_two;
  logic [REG_W-1:0]  r2_base;
  logic              fit_cur, fit_two;
  logic [REG_W-1:0]  grant_a;
  logic              grant_ok;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || rsp.ready);

  assign rsp.valid          = out_valid_r;
  assign rsp.result_address = out_addr_r;
  assign rsp.usable_bytes   = out_use_r;
  assign rsp.status         = out_stat_r;

  always_comb begin
    need        = NEED_W'(req_r) + NEED_W'(8);
    k_alloc     = '0;
    small_alloc = 1'b0;
    for (int i = SMALL_CLASSES - 1; i >= 0; i--) begin
      if ((64'(16) << i) >= 64'(need)) begin
        k_alloc     = K_W'(i);
        small_alloc = 1'b1;
      end
    end
    round_mask = (CAPB_W'(1) << BIG_ROUND_BITS) - CAPB_W'(1);
    big_cap    = (CAPB_W'(need) + round_mask) & ~round_mask;
  end

  always_comb begin
    k_free = K_W'(SMALL_CLASSES - 1);
    for (int i = SMALL_CLASSES - 2; i >= 0; i--) begin
      if ((64'(1) << i) >= 64'(mem_rdata.cap_g)) begin
        k_free = K_W'(i);
      end
    end
    small_free = 64'(mem_rdata.cap_g) <= (64'(1) << (SMALL_CLASSES - 1));
  end

  always_comb begin
    lim_one  = (SUM_W'(cfg.r1_end) < SPACE) ? SUM_W'(cfg.r1_end) : SPACE;
    lim_two  = (SUM_W'(cfg.r2_end) < SPACE) ? SUM_W'(cfg.r2_end) : SPACE;
    lim_cur  = r2_r ? lim_two : lim_one;
    r2_base  = {cfg.r2_start[REG_W-1:GRAN_BITS], GRAN_BITS'(0)};
    sum_cur  = SUM_W'(bump_r) + SUM_W'(capb_r);
    sum_two  = SUM_W'(r2_base) + SUM_W'(capb_r);
    fit_cur  = sum_cur <= lim_cur;
    fit_two  = sum_two <= lim_two;
    grant_ok = fit_cur || (!r2_r && fit_two);
    grant_a  = fit_cur ? bump_r : r2_base;
  end

  always_comb begin
    state_nxt    = state_r;
    heads_nxt    = heads_r;
    big_head_nxt = big_head_r;
    bump_nxt     = bump_r;
    r2_nxt       = r2_r;
    clr_nxt      = clr_r;
    k_nxt        = k_r;
    cap_g_nxt    = cap_g_r;
    capb_nxt     = capb_r;
    g_nxt        = g_r;
    cur_nxt      = cur_r;
    prev_g_nxt   = prev_g_r;
    prev_hdr_nxt = prev_hdr_r;
    prev_ok_nxt  = prev_ok_r;
    steps_nxt    = steps_r;
    res_addr_nxt = res_addr_r;
    res_use_nxt  = res_use_r;
    res_stat_nxt = res_stat_r;
    mem_we       = 1'b0;
    mem_waddr    = g_r;
    mem_wdata    = '0;
    mem_raddr    = g_r;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + GRAN_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_addr_nxt = '0;
        res_use_nxt  = '0;
        res_stat_nxt = STAT_OK;
        state_nxt    = S_DONE;
        if (cmd_r == CMD_ALLOC) begin
          if (small_alloc) begin
            k_nxt     = k_alloc;
            cap_g_nxt = CAPG_W'(1) << k_alloc;
            capb_nxt  = CAPB_W'(16) << k_alloc;
            if (heads_r[k_alloc] != '0) begin
              g_nxt     = GRAN_W'(heads_r[k_alloc] - LINK_W'(1));
              mem_raddr = GRAN_W'(heads_r[k_alloc] - LINK_W'(1));
              state_nxt = S_POP_EVAL;
            end else begin
              state_nxt = S_BUMP;
            end
          end else begin
            capb_nxt    = big_cap;
            cur_nxt     = big_head_r;
            prev_ok_nxt = 1'b0;
            steps_nxt   = '0;
            state_nxt   = S_WALK_RD;
          end
        end else if (cmd_r == CMD_FREE || cmd_r == CMD_QUERY) begin
          if (ptr_r == '0) begin
            res_stat_nxt = STAT_NULL;
          end else if (ptr_r[GRAN_BITS-1:0] != GRAN_BITS'(8)) begin
            res_stat_nxt = STAT_NOT_HEAP;
          end else begin
            g_nxt     = ptr_r[ADDR_BITS-1:GRAN_BITS];
            mem_raddr = ptr_r[ADDR_BITS-1:GRAN_BITS];
            state_nxt = S_HDR_EVAL;
          end
        end
      end
      S_POP_EVAL: begin
        heads_nxt[k_r]  = mem_rdata.next;
        mem_we          = 1'b1;
        mem_wdata.valid = 1'b1;
        mem_wdata.cap_g = cap_g_r;
        mem_wdata.next  = mem_rdata.next;
        res_addr_nxt    = PTR_W'({g_r, GRAN_BITS'(8)});
        res_use_nxt     = REG_W'(capb_r) - REG_W'(8);
        state_nxt       = S_DONE;
      end
      S_WALK_RD: begin
        if (cur_r == '0 || steps_r == LINK_W'(1 << GRAN_W)) begin
          state_nxt = S_BUMP;
        end else begin
          mem_raddr = GRAN_W'(cur_r - LINK_W'(1));
          g_nxt     = GRAN_W'(cur_r - LINK_W'(1));
          state_nxt = S_WALK_EVAL;
        end
      end
      S_WALK_EVAL: begin
        if (CAPB_W'({mem_rdata.cap_g, GRAN_BITS'(0)}) >= capb_r) begin
          res_addr_nxt = PTR_W'({g_r, GRAN_BITS'(8)});
          res_use_nxt  = REG_W'({mem_rdata.cap_g, GRAN_BITS'(0)}) - REG_W'(8);
          cap_g_nxt    = mem_rdata.cap_g;
          mem_we       = 1'b1;
          if (!prev_ok_r) begin
            big_head_nxt    = mem_rdata.next;
            mem_wdata.valid = 1'b1;
            mem_wdata.cap_g = mem_rdata.cap_g;
            mem_wdata.next  = mem_rdata.next;
            state_nxt       = S_DONE;
          end else begin
            // Unlink from the predecessor first, then mark the block taken.
            mem_waddr      = prev_g_r;
            mem_wdata      = prev_hdr_r;
            mem_wdata.next = mem_rdata.next;
            state_nxt      = S_LINK_FIX;
          end
        end else begin
          prev_hdr_nxt = mem_rdata;
          prev_g_nxt   = g_r;
          prev_ok_nxt  = 1'b1;
          cur_nxt      = mem_rdata.next;
          steps_nxt    = steps_r + LINK_W'(1);
          state_nxt    = S_WALK_RD;
        end
      end
      S_LINK_FIX: begin
        mem_we          = 1'b1;
        mem_wdata.valid = 1'b1;
        mem_wdata.cap_g = cap_g_r;
        state_nxt       = S_DONE;
      end
      S_BUMP: begin
        if (!fit_cur && !r2_r) begin
          r2_nxt   = 1'b1;
          bump_nxt = r2_base;
        end
        if (grant_ok) begin
          bump_nxt        = fit_cur ? REG_W'(sum_cur) : REG_W'(sum_two);
          mem_we          = 1'b1;
          mem_waddr       = grant_a[ADDR_BITS-1:GRAN_BITS];
          mem_wdata.valid = 1'b1;
          mem_wdata.cap_g = CAPG_W'(capb_r >> GRAN_BITS);
          res_addr_nxt    = PTR_W'({grant_a[ADDR_BITS-1:GRAN_BITS], GRAN_BITS'(8)});
          res_use_nxt     = REG_W'(capb_r) - REG_W'(8);
          res_stat_nxt    = STAT_OK;
        end else begin
          res_addr_nxt = '0;
          res_use_nxt  = '0;
          res_stat_nxt = STAT_OOM;
        end
        state_nxt = S_DONE;
      end
      S_HDR_EVAL: begin
        if (!mem_rdata.valid) begin
          res_stat_nxt = STAT_NOT_HEAP;
        end else if (cmd_r == CMD_QUERY) begin
          res_use_nxt = REG_W'({mem_rdata.cap_g, GRAN_BITS'(0)}) - REG_W'(8);
        end else begin
          mem_we          = 1'b1;
          mem_wdata.valid = 1'b0;
          mem_wdata.cap_g = mem_rdata.cap_g;
          if (small_free) begin
            mem_wdata.next    = heads_r[k_free];
            heads_nxt[k_free] = LINK_W'(g_r) + LINK_W'(1);
          end else begin
            mem_wdata.next = big_head_r;
            big_head_nxt   = LINK_W'(g_r) + LINK_W'(1);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A start write reloads the pointer only before anything was bumped.
    if (cfg_ld.start_we && !r2_r &&
        bump_r == {cfg.r1_start[REG_W-1:GRAN_BITS], GRAN_BITS'(0)}) begin
      bump_nxt = {cfg_ld.value[REG_W-1:GRAN_BITS], GRAN_BITS'(0)};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      big_head_r  <= '0;
      bump_r      <= {R1_START_RST[REG_W-1:GRAN_BITS], GRAN_BITS'(0)};
      r2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SMALL_CLASSES; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      big_head_r  <= big_head_nxt;
      bump_r      <= bump_nxt;
      r2_r        <= r2_nxt;
      out_valid_r <= out_valid_nxt;
      heads_r     <= heads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= req.cmd;
      req_r <= req.request_bytes;
      ptr_r <= req.block_address;
    end
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_use_r  <= res_use_r;
      out_stat_r <= res_stat_r;
    end
    k_r        <= k_nxt;
    cap_g_r    <= cap_g_nxt;
    capb_r     <= capb_nxt;
    g_r        <= g_nxt;
    cur_r      <= cur_nxt;
    prev_g_r   <= prev_g_nxt;
    prev_hdr_r <= prev_hdr_nxt;
    prev_ok_r  <= prev_ok_nxt;
    steps_r    <= steps_nxt;
    res_addr_r <= res_addr_nxt;
    res_use_r  <= res_use_nxt;
    res_stat_r <= res_stat_nxt;
  end

  `SCHA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_r == S_DECODE)
  `SCHA_ASSERT_NEXT(a_region_two_sticks, clk, rst_n, r2_r, r2_r)
  `SCHA_ASSERT_NOW(a_walk_bounded, clk, rst_n, state_r == S_WALK_EVAL,
                   steps_r < LINK_W'(1 << GRAN_W))
  `SCHA_ASSERT_NOW(a_no_request_in_clear, clk, rst_n, state_r == S_CLEAR,
                   !req.ready && mem_we)

endmodule

[rtl/size_class_heap_allocator.sv]
// Segregated free-list heap allocator. Each request allocates, frees or
// queries a block; every request returns exactly one response. Small
// allocations (request plus an 8-byte header up to 16 << (SMALL_CLASSES-1)
// bytes) pop a per-class free stack or cut from the bump pointer; larger ones
// are rounded to 64 KiB and taken first-fit from the big free list. Block
// headers live in one single-port-read, single-port-write memory with a
// registered read. A command that needs no header lookup (null pointer,
// misaligned pointer, unknown command) answers straight from decode; a
// query reads the block's header and a free reads and then rewrites it; a
// small pop does the same to the head block of its class, and a bump
// allocate writes a new header; a big allocate reads the big free list
// block by block until one fits, then unlinks it, fixing the predecessor's
// link when it is not at the head, and falls back to the bump pointer when
// none fits. A new request is accepted as soon as the previous one
// finishes, even while its response still waits to be taken. After reset
// the header memory is cleared one entry per cycle, all 2^(ADDR_BITS-4) =
// 65536 entries; no request is accepted during that pass, while
// configuration writes are taken as ever. Region registers should be
// written only while the block is idle.
module size_class_heap_allocator import scha_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  scha_req_if.sink             in_req,
  scha_rsp_if.source           out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  // Region registers. Writes beyond the last index are dropped.
  cfg_t    cfg_r, cfg_nxt;
  cfg_ld_t cfg_ld;

  logic              mem_we;
  logic [GRAN_W-1:0] mem_waddr;
  hdr_t              mem_wdata;
  logic [GRAN_W-1:0] mem_raddr;
  logic [HDR_W-1:0]  mem_rdata_raw;
  hdr_t              mem_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_R1_START: cfg_nxt.r1_start = cfg_wdata;
        REG_R1_END:   cfg_nxt.r1_end   = cfg_wdata;
        REG_R2_START: cfg_nxt.r2_start = cfg_wdata;
        REG_R2_END:   cfg_nxt.r2_end   = cfg_wdata;
        default: begin
        end
      endcase
    end
    // The controller compares the pointer against the old start value.
    cfg_ld.start_we = cfg_we && (cfg_index == REG_R1_START);
    cfg_ld.value    = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.r1_start <= R1_START_RST;
      cfg_r.r1_end   <= R1_END_RST;
      cfg_r.r2_start <= R2_START_RST;
      cfg_r.r2_end   <= R2_END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign mem_rdata = hdr_t'(mem_rdata_raw);

  // Header store: one entry per 16-byte granule.
  scha_hdr_ram #(
    .W  (HDR_W),
    .AW (GRAN_W)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (HDR_W'(mem_wdata)),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  // Command sequencer: decodes requests and runs the header read-modify-write.
  scha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .rsp       (out_rsp),
    .cfg       (cfg_r),
    .cfg_ld    (cfg_ld),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

[tb/scha_tb_ifs.sv]
// The block's channel interfaces, scha_req_if and scha_rsp_if, come from
// rtl/scha_ifs.sv. The testbench uses them as they are and defines no
// interface of its own. This file holds only the testbench's own types.
package scha_tb_pkg;
  import scha_pkg::*;

  // One allocator request: the command and both of its operands.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REG_W-1:0] bytes;
    logic [PTR_W-1:0] addr;
  } alloc_req_t;

  // One allocator response, as predicted by the model or typed into a directed row.
  typedef struct packed {
    logic [PTR_W-1:0]  addr;
    logic [REG_W-1:0]  usable;
    logic [STAT_W-1:0] status;
  } alloc_rsp_t;
endpackage

[tb/size_class_heap_allocator_tb.sv]
// Self-checking testbench for size_class_heap_allocator.
// A directed table comes first. Its rows exercise the null pointer, misaligned
// and unknown pointers, double frees, both size classes at their extremes,
// region overflow and the unused command code. Three random phases follow.
// They consist mostly of allocate, free and query sequences on live blocks.
// Each response is compared with a behavioral model of the allocator that the
// testbench keeps itself. The region registers are changed between phases.
module size_class_heap_allocator_tb;
  import scha_pkg::*;
  import scha_tb_pkg::*;

  localparam int NGRANULE = 1 << GRAN_W;
  localparam int WATCH_LIMIT = 200000;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  scha_req_if in_req ();
  scha_rsp_if out_rsp ();

  size_class_heap_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // The testbench's own copy of the allocator state.
  logic [63:0] region_reg [4];
  int unsigned class_head [SMALL_CLASSES];
  int unsigned big_head;
  longint unsigned bump;
  bit in_r2;
  bit hdr_valid [NGRANULE];
  longint unsigned hdr_cap [NGRANULE];
  int unsigned hdr_next [NGRANULE];

  // Pointers that the random traffic frees or queries later.
  logic [PTR_W-1:0] live_ptrs [$];
  alloc_rsp_t expected_rsps [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  task automatic model_reset();
    region_reg[0] = R1_START_RST;
    region_reg[1] = R1_END_RST;
    region_reg[2] = R2_START_RST;
    region_reg[3] = R2_END_RST;
    foreach (class_head[i]) class_head[i] = 0;
    big_head = 0;
    bump = region_reg[0] & ~64'd15;
    in_r2 = 1'b0;
    foreach (hdr_valid[i]) begin
      hdr_valid[i] = 1'b0;
      hdr_cap[i] = 0;
      hdr_next[i] = 0;
    end
  endtask

  // A region end is capped at the size of the address space.
  function automatic longint unsigned space_cap(longint unsigned e);
    return (e < (64'd1 << ADDR_BITS)) ? e : (64'd1 << ADDR_BITS);
  endfunction

  // Cut a block from the bump pointer. When region one is full the pointer
  // moves to region two once; a block that does not fit there fails.
  function automatic bit bump_cut(longint unsigned cap, output longint unsigned a);
    longint unsigned lim;
    lim = space_cap(in_r2 ? region_reg[3] : region_reg[1]);
    if (bump + cap > lim) begin
      if (in_r2) return 1'b0;
      in_r2 = 1'b1;
      bump = region_reg[2] & ~64'd15;
      if (bump + cap > space_cap(region_reg[3])) return 1'b0;
    end
    a = bump;
    bump += cap;
    return 1'b1;
  endfunction

  function automatic alloc_rsp_t predict_alloc(longint unsigned req);
    alloc_rsp_t r;
    longint unsigned need, cap, a, mask;
    int unsigned k, g, prev, cur, steps;
    bit found;
    r = '{default: '0};
    need = req + 8;
    k = 0;
    a = 0;
    found = 1'b0;
    while (k < SMALL_CLASSES && (64'd16 << k) < need) k++;
    if (k < SMALL_CLASSES) begin
      cap = 64'd16 << k;
      if (class_head[k] != 0 && class_head[k] <= NGRANULE) begin
        g = class_head[k] - 1;
        a = longint'(g) << GRAN_BITS;
        class_head[k] = hdr_next[g];
        found = 1'b1;
      end
    end else begin
      // First fit over the big free list. The walk stops after as many
      // steps as there are granules.
      mask = (64'd1 << BIG_ROUND_BITS) - 1;
      cap = (need + mask) & ~mask;
      prev = 0;
      cur = big_head;
      steps = 0;
      while (cur != 0 && cur <= NGRANULE && steps < NGRANULE) begin
        g = cur - 1;
        if (hdr_cap[g] >= cap) begin
          a = longint'(g) << GRAN_BITS;
          if (prev == 0) big_head = hdr_next[g];
          else hdr_next[prev - 1] = hdr_next[g];
          cap = hdr_cap[g];
          found = 1'b1;
          break;
        end
        prev = cur;
        cur = hdr_next[g];
        steps++;
      end
    end
    if (!found && !bump_cut(cap, a)) begin
      r.status = STAT_OOM;
      return r;
    end
    g = (a >> GRAN_BITS) & (NGRANULE - 1);
    hdr_cap[g] = cap;
    hdr_valid[g] = 1'b1;
    r.addr = PTR_W'(a + 8);
    r.usable = REG_W'(cap - 8);
    r.status = STAT_OK;
    return r;
  endfunction

  // Works out the response to one request and updates the model state.
  function automatic alloc_rsp_t predict_rsp(alloc_req_t q);
    alloc_rsp_t r;
    longint unsigned a;
    int unsigned g, k;
    r = '{default: '0};
    if (q.cmd == CMD_ALLOC) return predict_alloc(q.bytes);
    if (q.cmd != CMD_FREE && q.cmd != CMD_QUERY) return r;
    if (q.addr == 0) begin
      r.status = STAT_NULL;
      return r;
    end
    // A valid user pointer is 8 bytes past a granule start, and that
    // granule's header must still be marked valid.
    a = longint'(q.addr) - 8;
    if (q.addr < 8 || (a & 15) != 0 || !hdr_valid[a >> GRAN_BITS]) begin
      r.status = STAT_NOT_HEAP;
      return r;
    end
    g = a >> GRAN_BITS;
    if (q.cmd == CMD_QUERY) begin
      r.usable = REG_W'(hdr_cap[g] - 8);
      return r;
    end
    hdr_valid[g] = 1'b0;
    if (hdr_cap[g] <= (64'd16 << (SMALL_CLASSES - 1))) begin
      k = 0;
      while (k < SMALL_CLASSES - 1 && (64'd16 << k) < hdr_cap[g]) k++;
      hdr_next[g] = class_head[k];
      class_head[k] = g + 1;
    end else begin
      hdr_next[g] = big_head;
      big_head = g + 1;
    end
    return r;
  endfunction

  // Writes one region register, in the block and in the model. Writing
  // region one's start also moves the bump pointer, but only while nothing
  // has been cut from region one yet.
  task automatic write_region(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx > REG_R2_END) return;
    if (idx == REG_R1_START && !in_r2 && bump == (region_reg[0] & ~64'd15))
      bump = val & ~64'd15;
    region_reg[idx] = val;
  endtask

  // Holds the sender back until every expected response has come, then lets
  // the clock run on before returning.
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Sends one request after a random gap and stores its prediction when it
  // is accepted. When chk is set, the typed-in response of a directed row is
  // checked against the prediction as well. Valid stays high after an
  // accept and drops when the next request draws a gap or when wait_idle holds the sender back.
  task automatic send_req(alloc_req_t q, bit chk = 1'b0, alloc_rsp_t want = '{default: '0});
    alloc_rsp_t r;
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.cmd <= q.cmd;
    in_req.request_bytes <= q.bytes;
    in_req.block_address <= q.addr;
    do @(posedge clk); while (!in_req.ready);
    r = predict_rsp(q);
    if (chk && r != want) begin
      $error("directed row: model gives status %0d addr %0h usable %0d, table gives %0d %0h %0d",
             r.status, r.addr, r.usable, want.status, want.addr, want.usable);
      errors++;
    end
    if (r.status == STAT_OK && q.cmd == CMD_ALLOC) live_ptrs.push_back(r.addr);
    expected_rsps.push_back(r);
  endtask

  // Responses are sampled at the edge, after the ready drawn for them has
  // been held for its random delay.
  int rdy_wait = 0;
  always @(posedge clk) begin
    alloc_rsp_t e;
    int w;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response without a pending request");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_rsp.result_address !== e.addr) begin
            $error("result_address expected %0h actual %0h", e.addr, out_rsp.result_address);
            errors++;
          end
          if (out_rsp.usable_bytes !== e.usable) begin
            $error("usable_bytes expected %0d actual %0d", e.usable, out_rsp.usable_bytes);
            errors++;
          end
          if (out_rsp.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_rsp.status);
            errors++;
          end
        end
        w = $urandom_range(0, 3);
        rdy_wait <= w;
        out_rsp.ready <= (w == 0);
      end else if (rdy_wait > 0) begin
        rdy_wait <= rdy_wait - 1;
        out_rsp.ready <= (rdy_wait == 1);
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // The watchdog ends the run if no request or response has moved for too
  // long. Its count is held at zero in reset and while, before the end of stimulus, nothing is sent or pending.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (!in_req.valid && expected_rsps.size() == 0 && !stim_done))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Directed rows. A row with chk set carries a response read off by hand.
  typedef struct {
    alloc_req_t q;
    bit chk;
    alloc_rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{CMD_FREE, 21'd0, 20'd0}, 1'b1, '{20'd0, 21'd0, STAT_NULL}},
    '{'{CMD_QUERY, 21'd0, 20'd0}, 1'b1, '{20'd0, 21'd0, STAT_NULL}},
    '{'{CMD_FREE, 21'd0, 20'd4}, 1'b1, '{20'd0, 21'd0, STAT_NOT_HEAP}},
    '{'{CMD_QUERY, 21'd0, 20'hFFFFF}, 1'b1, '{20'd0, 21'd0, STAT_NOT_HEAP}},
    '{'{CMD_FREE, 21'd0, 20'd4104}, 1'b1, '{20'd0, 21'd0, STAT_NOT_HEAP}},
    '{'{CMD_ALLOC, 21'd0, 20'd0}, 1'b1, '{20'd4104, 21'd8, STAT_OK}},
    '{'{CMD_QUERY, 21'd0, 20'd4104}, 1'b1, '{20'd0, 21'd8, STAT_OK}},
    '{'{CMD_QUERY, 21'd0, 20'd4105}, 1'b1, '{20'd0, 21'd0, STAT_NOT_HEAP}},
    '{'{CMD_FREE, 21'd0, 20'd4104}, 1'b1, '{20'd0, 21'd0, STAT_OK}},
    '{'{CMD_FREE, 21'd0, 20'd4104}, 1'b1, '{20'd0, 21'd0, STAT_NOT_HEAP}},
    '{'{CMD_ALLOC, 21'd8, 20'd0}, 1'b1, '{20'd4104, 21'd8, STAT_OK}},
    '{'{CMD_ALLOC, 21'd9, 20'd0}, 1'b0, '{default: '0}},
    '{'{CMD_ALLOC, 21'd32760, 20'd0}, 1'b0, '{default: '0}},
    '{'{CMD_ALLOC, 21'd32761, 20'd0}, 1'b0, '{default: '0}},
    '{'{CMD_NONE, 21'h1FFFFF, 20'hFFFFF}, 1'b1, '{20'd0, 21'd0, STAT_OK}},
    '{'{CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF}, 1'b1, '{20'd0, 21'd0, STAT_OOM}},
    '{'{CMD_ALLOC, 21'd1048576, 20'd0}, 1'b1, '{20'd0, 21'd0, STAT_OOM}},
    '{'{CMD_ALLOC, 21'd400000, 20'd0}, 1'b0, '{default: '0}},
    '{'{CMD_ALLOC, 21'd300000, 20'd0}, 1'b0, '{default: '0}},
    '{'{CMD_ALLOC, 21'd300000, 20'd0}, 1'b0, '{default: '0}}
  };

  // Draws one random request. Most requests are well formed: allocations
  // of a mostly small size, and frees or queries of live blocks.
  function automatic alloc_req_t rand_req();
    alloc_req_t q;
    int sel, idx;
    q.bytes = REG_W'($urandom());
    q.addr = PTR_W'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      q.cmd = CMD_ALLOC;
      if (sel < 38) q.bytes = REG_W'($urandom_range(0, 2000));
      else if (sel < 42) q.bytes = REG_W'($urandom_range(0, 40000));
      else q.bytes = REG_W'($urandom_range(32761, 200000));
    end else if (sel < 90 && live_ptrs.size() != 0) begin
      q.cmd = (sel < 78) ? CMD_FREE : CMD_QUERY;
      idx = $urandom_range(0, live_ptrs.size() - 1);
      q.addr = live_ptrs[idx];
      if (q.cmd == CMD_FREE && $urandom_range(0, 3) != 0) live_ptrs.delete(idx);
    end else begin
      q.cmd = CMD_W'($urandom_range(0, 3));
      if (sel % 3 == 0) q.addr = 0;
    end
    return q;
  endfunction

  initial begin
    in_req.valid = 1'b0;
    in_req.cmd = '0;
    in_req.request_bytes = '0;
    in_req.block_address = '0;
    out_rsp.ready = 1'b0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_req(dir_rows[i].q, dir_rows[i].chk, dir_rows[i].want);
    wait_idle();

    // Phase 1: the registers at their extremes. Both regions become empty,
    // so that new blocks come only from the free lists.
    write_region(REG_R1_START, 21'd16);
    write_region(REG_R1_END, 21'd16);
    write_region(REG_R2_START, 21'd1048576);
    write_region(REG_R2_END, 21'd1048576);
    write_region(3'd7, 21'h1FFFFF);
    repeat (400) send_req(rand_req());
    wait_idle();

    // Phase 2: region two is widened, but the bump pointer stays where it was.
    write_region(REG_R2_START, 21'd200031);
    write_region(REG_R2_END, 21'h1FFFFF);
    repeat (600) send_req(rand_req());
    wait_idle();

    // Phase 3: all registers but region two's start get their reset values back. The bump
    // pointer is already in region two, so allocations must be served from the free lists.
    write_region(REG_R1_START, R1_START_RST);
    write_region(REG_R1_END, R1_END_RST);
    write_region(REG_R2_END, R2_END_RST);
    repeat (550) send_req(rand_req());

    stim_done = 1'b1;
    wait_idle();
    if (errors == 0 && expected_rsps.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[size_class_heap_allocator.f]
+incdir+rtl
rtl/scha_pkg.sv
rtl/scha_ifs.sv
rtl/scha_hdr_ram.sv
rtl/scha_ctrl.sv
rtl/size_class_heap_allocator.sv
tb/scha_tb_ifs.sv
tb/size_class_heap_allocator_tb.sv
